@@ src/cls_pkg.sv @@
// Shared constants and types for the conveyor length sorter.
// No dependencies; cls_front, cls_back and the top level refer to it by scoped names.
package cls_pkg;

  // register map, word index = paddr[4:2]
  localparam logic [2:0] REG_THRESH = 3'd0;
  localparam logic [2:0] REG_SPEED  = 3'd1;
  localparam logic [2:0] REG_SMALL  = 3'd2;
  localparam logic [2:0] REG_MEDIUM = 3'd3;
  localparam logic [2:0] REG_LARGE  = 3'd4;

  localparam logic [11:0] THRESH_RESET = 12'd3500;
  localparam logic [17:0] SMALL_RESET  = 18'd50000;
  localparam logic [17:0] MEDIUM_RESET = 18'd75000;
  localparam logic [17:0] LARGE_RESET  = 18'd100000;

  // size classes
  localparam logic [2:0] CLS_TOO_SMALL = 3'd0;
  localparam logic [2:0] CLS_SMALL     = 3'd1;
  localparam logic [2:0] CLS_MEDIUM    = 3'd2;
  localparam logic [2:0] CLS_LARGE     = 3'd3;
  localparam logic [2:0] CLS_TOO_LARGE = 3'd4;
  localparam int         NUM_CLASSES   = 5;

  localparam logic [11:0] TGT_SMALL  = 12'd3140;
  localparam logic [11:0] TGT_MEDIUM = 12'd3276;
  localparam logic [11:0] TGT_LARGE  = 12'd3400;
  localparam logic [11:0] SKID_RESET = 12'd3270;

  localparam logic [24:0] DUR_CAP = 25'd16777216;
  localparam logic [19:0] LEN_MAX = 20'hFFFFF;
  localparam logic [11:0] SPEED_KNEE = 12'd1500;

  // datapath width of the length words; the delay divider retires two quotient bits a cycle
  localparam int DIV_W     = 40;
  localparam int DIV_STEPS = DIV_W / 2;

  typedef logic [15:0] count_t;

endpackage

@@ src/cls_if.sv @@
// Handshake channels of the conveyor length sorter: sample words in, result words out.
// Depends on nothing.
interface cls_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] sensor_sample;
  logic        clear_counts;
  modport source (output valid, sensor_sample, clear_counts, input ready);
  modport sink (input valid, sensor_sample, clear_counts, output ready);
endinterface

interface cls_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] skid_target;
  logic        object_done;
  logic [2:0]  size_class;
  logic [19:0] measured_um;
  logic        queue_dropped;
  logic [15:0] count_too_small;
  logic [15:0] count_small;
  logic [15:0] count_medium;
  logic [15:0] count_large;
  logic [15:0] count_too_large;
  modport source (output valid, skid_target, object_done, size_class, measured_um,
                  queue_dropped, count_too_small, count_small, count_medium,
                  count_large, count_too_large, input ready);
  modport sink (input valid, skid_target, object_done, size_class, measured_um,
                queue_dropped, count_too_small, count_small, count_medium,
                count_large, count_too_large, output ready);
endinterface

@@ src/conveyor_length_sorter.sv @@
// Top level of the conveyor length sorter: APB registers, front, job queue, back.
// Depends on cls_pkg, cls_if, cls_fifo, cls_front and cls_back.
//
//   channel   dir  payload
//   in_ch     in   sensor_sample[12], clear_counts
//   out_ch    out  skid_target, object_done, size_class, measured_um, queue_dropped,
//                  five 16-bit class counts
//   apb       in   five registers at byte addresses 0,4,8,12,16
//
// A sample with no finished object passes the back end through idle and output only. A
// finished object passes setup (idle, multiply, numerator), a shift-add divide by ten
// (run twice above 1500 mm/s), classing, the delay divide (skipped at zero speed), the
// queue update and output, where it waits out any stall on out_ch.
// The front takes a word every cycle into a 2-entry job queue and stalls only when it
// is full. rst is synchronous and clears all control state, counters and the skid
// setpoint (3270).
module conveyor_length_sorter #(
  parameter int QUEUE_DEPTH = 8,
  parameter int TIME_WIDTH  = 32
) (
  input  logic        clk,
  input  logic        rst,
  cls_in_if.sink      in_ch,
  cls_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int JW = TIME_WIDTH + 27;

  logic [11:0] threshold, speed;
  logic [17:0] small_nom, medium_nom, large_nom;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= cls_pkg::THRESH_RESET;
      speed      <= '0;
      small_nom  <= cls_pkg::SMALL_RESET;
      medium_nom <= cls_pkg::MEDIUM_RESET;
      large_nom  <= cls_pkg::LARGE_RESET;
    end else if (wr_en) begin
      if (reg_idx == cls_pkg::REG_THRESH) threshold  <= pwdata[11:0];
      if (reg_idx == cls_pkg::REG_SPEED)  speed      <= pwdata[11:0];
      if (reg_idx == cls_pkg::REG_SMALL)  small_nom  <= pwdata[17:0];
      if (reg_idx == cls_pkg::REG_MEDIUM) medium_nom <= pwdata[17:0];
      if (reg_idx == cls_pkg::REG_LARGE)  large_nom  <= pwdata[17:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == cls_pkg::REG_THRESH) prdata = 32'(threshold);
    if (reg_idx == cls_pkg::REG_SPEED)  prdata = 32'(speed);
    if (reg_idx == cls_pkg::REG_SMALL)  prdata = 32'(small_nom);
    if (reg_idx == cls_pkg::REG_MEDIUM) prdata = 32'(medium_nom);
    if (reg_idx == cls_pkg::REG_LARGE)  prdata = 32'(large_nom);
  end

  logic          job_push, job_space, job_valid, job_take;
  logic [JW-1:0] job_in, job_head;

  cls_front #(.TW(TIME_WIDTH)) u_front (
    .clk, .rst, .in_ch,
    .threshold (threshold),
    .job_space (job_space),
    .job_push  (job_push),
    .job_data  (job_in)
  );

  cls_fifo #(.W(JW)) u_jobs (
    .clk, .rst,
    .push      (job_push),
    .push_data (job_in),
    .can_push  (job_space),
    .pop       (job_take),
    .head      (job_head),
    .not_empty (job_valid)
  );

  cls_back #(.QD(QUEUE_DEPTH), .TW(TIME_WIDTH)) u_back (
    .clk, .rst,
    .job_valid  (job_valid),
    .job_data   (job_head),
    .job_take   (job_take),
    .speed      (speed),
    .small_nom  (small_nom),
    .medium_nom (medium_nom),
    .large_nom  (large_nom),
    .out_ch
  );
endmodule

@@ src/cls_fifo.sv @@
// Two-entry job queue between the front and back of the sorter.
// Depends on nothing.
module cls_fifo #(
  parameter int W = 59
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         can_push,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         not_empty
);
  logic [W-1:0] slot0, slot1;
  logic [1:0]   fill;

  assign can_push  = (fill != 2'd2);
  assign not_empty = (fill != 2'd0);
  assign head      = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= 2'd0;
    end else begin
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
    if (pop) begin
      slot0 <= (push && fill == 2'd1) ? push_data : slot1;
      if (push && fill == 2'd2) slot1 <= push_data;
    end else if (push) begin
      if (fill == 2'd0) slot0 <= push_data;
      else slot1 <= push_data;
    end
  end
endmodule

@@ src/cls_front.sv @@
// Front end: tick counter and object presence detection; emits one job per sample.
// Depends on cls_pkg and cls_in_if.
module cls_front #(
  parameter int TW = 32
) (
  input  logic           clk,
  input  logic           rst,
  cls_in_if.sink         in_ch,
  input  logic [11:0]    threshold,
  input  logic           job_space,
  output logic           job_push,
  output logic [TW+26:0] job_data
);
  logic [TW-1:0] tick_now;
  logic [TW-1:0] entry_tick;
  logic          present;
  logic [TW-1:0] span;
  logic [47:0]   span_x;
  logic [24:0]   dur;
  logic          done;

  assign in_ch.ready = job_space;
  assign job_push    = in_ch.valid && job_space;

  assign span   = tick_now - entry_tick;
  assign span_x = 48'(span);
  assign dur    = (span_x > 48'(cls_pkg::DUR_CAP)) ? cls_pkg::DUR_CAP : span_x[24:0];
  assign done   = present && (in_ch.sensor_sample < threshold);
  assign job_data = {tick_now, dur, done, in_ch.clear_counts};

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now   <= '0;
      entry_tick <= '0;
      present    <= 1'b0;
    end else if (job_push) begin
      tick_now <= tick_now + 1'b1;
      if (!present) begin
        if (in_ch.sensor_sample > threshold) begin
          present    <= 1'b1;
          entry_tick <= tick_now;
        end
      end else if (done) begin
        present <= 1'b0;
      end
    end
  end
endmodule

@@ src/cls_back.sv @@
// Back end: length, classing, counters, due-tick divide and the skid target queue.
// Depends on cls_pkg and cls_out_if.
module cls_back #(
  parameter int QD = 8,
  parameter int TW = 32
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  input  logic [TW+26:0] job_data,
  output logic           job_take,
  input  logic [11:0]    speed,
  input  logic [17:0]    small_nom,
  input  logic [17:0]    medium_nom,
  input  logic [17:0]    large_nom,
  cls_out_if.source      out_ch
);
  localparam int IW = (QD > 1) ? $clog2(QD) : 1;
  localparam int FW = $clog2(QD + 1);
  localparam logic [63:0] MAXD = (64'd1 << (TW - 1)) - 64'd1;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_NUM, S_TEN, S_CLS, S_DIV2, S_FIN, S_OUT
  } state_t;

  state_t state;

  logic [TW-1:0]  due_ticks [QD];
  logic [11:0]    due_targets [QD];
  logic [FW-1:0]  fill;
  cls_pkg::count_t counts [cls_pkg::NUM_CLASSES];
  logic [11:0]    skid;

  logic [TW-1:0]  job_tick;
  logic [24:0]    job_dur;
  logic [36:0]    xr;
  logic           neg;
  logic [TW-1:0]  delay;
  logic [11:0]    target;
  logic           done_r, drop_r;
  logic [2:0]     cls_r;
  logic [19:0]    meas_r;

  // divider
  logic [12:0]    dv_rem;
  logic [cls_pkg::DIV_W-1:0] dv_quo;
  logic [11:0]    dv_div;
  logic [4:0]     dv_cnt;
  logic [12:0]    st_rem;
  logic [cls_pkg::DIV_W-1:0] st_quo;

  always_comb begin
    st_rem = dv_rem;
    st_quo = dv_quo;
    for (int k = 0; k < 2; k++) begin
      st_rem = {st_rem[11:0], st_quo[cls_pkg::DIV_W-1]};
      st_quo = {st_quo[cls_pkg::DIV_W-2:0], 1'b0};
      if (st_rem >= {1'b0, dv_div}) begin
        st_rem    = st_rem - {1'b0, dv_div};
        st_quo[0] = 1'b1;
      end
    end
  end

  // divide by ten with shifts and adds, eight steps a pass; /100 is two passes
  logic [cls_pkg::DIV_W-1:0] ten_n, ten_q, ten_qc;
  logic [4:0]     ten_r, ten_rc;
  logic [2:0]     ten_step;
  logic           ten_two, ten_nz;

  always_comb begin
    ten_qc = ten_q + cls_pkg::DIV_W'(ten_r > 5'd9);
    ten_rc = (ten_r > 5'd9) ? ten_r - 5'd10 : ten_r;
  end

  // numerator for the length divide
  logic signed [41:0] xs, num;
  logic [cls_pkg::DIV_W-1:0] mag;
  logic hi_speed;

  assign hi_speed = speed > cls_pkg::SPEED_KNEE;
  always_comb begin
    xs  = $signed({5'd0, xr}) - 42'sd25000
          - 42'(($signed({1'b0, speed}) - 13'sd1500) * 42'sd330);
    num = xs * 42'sd6 + 42'(({1'b0, small_nom} + {1'b0, large_nom}) * 19'd20);
    mag = num[41] ? cls_pkg::DIV_W'(-num) : cls_pkg::DIV_W'(num);
  end

  // length and class once the length divide is done
  logic signed [41:0] len, qs, sm_s, md_s, lg_s;
  logic [2:0]  cls_c;
  logic [11:0] tgt_c;
  logic [17:0] nom_c;
  logic [19:0] meas_c;
  logic [23:0] dist5;
  logic [63:0] qx;

  always_comb begin
    qs   = $signed({2'b0, ten_q});
    len  = neg ? (-qs - 42'(ten_nz)) : qs;
    sm_s = $signed(42'(small_nom));
    md_s = $signed(42'(medium_nom));
    lg_s = $signed(42'(large_nom));
    if (len < sm_s + 42'sd12500) begin
      cls_c = (len < sm_s - 42'sd15000) ? cls_pkg::CLS_TOO_SMALL : cls_pkg::CLS_SMALL;
      tgt_c = cls_pkg::TGT_SMALL;
      nom_c = small_nom;
    end else if (len <= md_s + 42'sd12500) begin
      cls_c = cls_pkg::CLS_MEDIUM;
      tgt_c = cls_pkg::TGT_MEDIUM;
      nom_c = medium_nom;
    end else begin
      cls_c = (len > lg_s + 42'sd20000) ? cls_pkg::CLS_TOO_LARGE : cls_pkg::CLS_LARGE;
      tgt_c = cls_pkg::TGT_LARGE;
      nom_c = large_nom;
    end
    if (len < 42'sd0) meas_c = '0;
    else if (len > $signed(42'(cls_pkg::LEN_MAX))) meas_c = cls_pkg::LEN_MAX;
    else meas_c = len[19:0];
    // never negative: twice a nominal stays below 860000
    dist5 = 24'((24'd860000 + 24'(speed) * 24'd145 - {5'd0, nom_c, 1'b0}) * 24'd5);
    qx = 64'(dv_quo);
  end

  logic [TW-1:0] jt_in;
  assign jt_in    = job_data[TW+26:27];
  assign job_take = (state == S_IDLE) && job_valid;

  logic [TW-1:0] rel_diff;
  assign rel_diff = jt_in - due_ticks[0];

  // fill was bumped in S_FIN; the new entry sits at fill-1
  logic          out_wrote;
  logic [FW-1:0] wr_pos;
  logic [IW-1:0] wr_idx;
  assign wr_pos = fill - 1'b1;
  assign wr_idx = wr_pos[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      skid  <= cls_pkg::SKID_RESET;
      for (int i = 0; i < cls_pkg::NUM_CLASSES; i++) counts[i] <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            job_tick <= jt_in;
            job_dur  <= job_data[26:2];
            if (fill != '0 && !rel_diff[TW-1]) begin
              skid <= due_targets[0];
              for (int i = 0; i < QD - 1; i++) begin
                due_ticks[i]   <= due_ticks[i+1];
                due_targets[i] <= due_targets[i+1];
              end
              fill <= fill - 1'b1;
            end
            if (job_data[0])
              for (int i = 0; i < cls_pkg::NUM_CLASSES; i++) counts[i] <= '0;
            done_r <= job_data[1];
            cls_r  <= cls_pkg::CLS_TOO_SMALL;
            meas_r <= '0;
            drop_r <= 1'b0;
            if (job_data[1]) begin
              state <= S_MUL;
            end else begin
              out_ch.valid <= 1'b1;
              state        <= S_OUT;
            end
          end
        end
        S_MUL: begin
          xr    <= job_dur * speed;
          state <= S_NUM;
        end
        S_NUM: begin
          ten_step <= '0;
          ten_nz   <= 1'b0;
          if (hi_speed) begin
            ten_n   <= mag;
            neg     <= num[41];
            ten_two <= 1'b1;
          end else begin
            ten_n   <= cls_pkg::DIV_W'(xr);
            neg     <= 1'b0;
            ten_two <= 1'b0;
          end
          state <= S_TEN;
        end
        S_TEN: begin
          ten_step <= ten_step + 1'b1;
          unique case (ten_step)
            3'd0: ten_q <= (ten_n >> 1) + (ten_n >> 2);
            3'd1: ten_q <= ten_q + (ten_q >> 4);
            3'd2: ten_q <= ten_q + (ten_q >> 8);
            3'd3: ten_q <= ten_q + (ten_q >> 16);
            3'd4: ten_q <= ten_q + (ten_q >> 32);
            3'd5: ten_q <= ten_q >> 3;
            3'd6: ten_r <= 5'(ten_n - ((ten_q << 3) + (ten_q << 1)));
            3'd7: begin
              // estimate is at most one low
              ten_q  <= ten_qc;
              ten_nz <= ten_nz || (ten_rc != 5'd0);
              if (ten_two) begin
                ten_n   <= ten_qc;
                ten_two <= 1'b0;
              end else begin
                state <= S_CLS;
              end
            end
          endcase
        end
        S_CLS: begin
          cls_r  <= cls_c;
          meas_r <= meas_c;
          target <= tgt_c;
          if (counts[cls_c] != 16'hFFFF) counts[cls_c] <= counts[cls_c] + 1'b1;
          dv_rem <= '0;
          dv_quo <= cls_pkg::DIV_W'(dist5);
          dv_div <= speed;
          dv_cnt <= 5'(cls_pkg::DIV_STEPS - 1);
          if (speed == '0) begin
            delay <= MAXD[TW-1:0];
            state <= S_FIN;
          end else begin
            state <= S_DIV2;
          end
        end
        S_DIV2: begin
          dv_rem <= st_rem;
          dv_quo <= st_quo;
          dv_cnt <= dv_cnt - 1'b1;
          if (dv_cnt == '0) state <= S_FIN;
        end
        S_FIN: begin
          // a zero-speed delay was already set in S_CLS
          if (speed != '0) delay <= (qx > MAXD) ? MAXD[TW-1:0] : qx[TW-1:0];
          state <= S_OUT;
          if (fill < FW'(QD)) begin
            fill <= fill + 1'b1;
          end else begin
            drop_r <= 1'b1;
          end
          out_ch.valid <= 1'b1;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
    // queue write on entry to S_OUT, after the delay has settled
    if (!rst && state == S_OUT && done_r && !drop_r && !out_wrote) begin
      due_ticks[wr_idx]   <= job_tick + delay;
      due_targets[wr_idx] <= target;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_wrote <= 1'b0;
    end else if (state == S_OUT) begin
      out_wrote <= 1'b1;
    end else begin
      out_wrote <= 1'b0;
    end
  end

  assign out_ch.skid_target     = skid;
  assign out_ch.object_done     = done_r;
  assign out_ch.size_class      = cls_r;
  assign out_ch.measured_um     = meas_r;
  assign out_ch.queue_dropped   = drop_r;
  assign out_ch.count_too_small = counts[cls_pkg::CLS_TOO_SMALL];
  assign out_ch.count_small     = counts[cls_pkg::CLS_SMALL];
  assign out_ch.count_medium    = counts[cls_pkg::CLS_MEDIUM];
  assign out_ch.count_large     = counts[cls_pkg::CLS_LARGE];
  assign out_ch.count_too_large = counts[cls_pkg::CLS_TOO_LARGE];
endmodule
